// File: src/assert_macros.svh
// Assertion macros shared by the page frame range allocator RTL.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent check on the rising clock, ignored while reset is asserted.
`define PFRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Concurrent check on the rising clock that also holds during reset.
`define PFRA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PFRA_ASSERT(lbl, prop, msg)
`define PFRA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: src/pfra_pkg.sv
// Package for the page frame range allocator: frame types, address constants,
// and the clip result structure. Depends on nothing.
package pfra_pkg;

  localparam int unsigned FRAME_W = 21;
  localparam int unsigned REND_W  = 34;

  typedef logic [FRAME_W-1:0] frame_t;

  // 4 GiB expressed as a frame number, and the address limits used by the clip.
  localparam frame_t        CAP_FRAME  = 21'h10_0000;
  localparam logic [63:0]   START_MAX  = 64'h0000_0000_FFFF_F000;
  localparam logic [63:0]   PHYS_CAP   = 64'h0000_0001_0000_0000;
  localparam logic [32:0]   LOW_FLOOR  = 33'h0_0010_0000;
  localparam logic [REND_W-1:0] PAGE_MASK = 34'h0_0000_0FFF;
  localparam logic [REND_W-1:0] REND_RESET = 34'h0_0010_0000;

  // Outcome of clipping one offered region.
  typedef struct packed {
    logic   drop;
    frame_t start_frame;
    frame_t end_frame;
  } clip_res_t;

endpackage

// File: src/pfra_table.sv
// Range table memory: first and limit frame per entry, one write port and
// one registered read port. Depends on pfra_pkg.
module pfra_table
  import pfra_pkg::*;
#(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  frame_t        wr_first,
  input  frame_t        wr_limit,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output frame_t        rd_first,
  output frame_t        rd_limit
);

  logic [2*FRAME_W-1:0] mem [DEPTH];
  logic [2*FRAME_W-1:0] rd_word_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_limit, wr_first};
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  assign rd_first = rd_word_r[FRAME_W-1:0];
  assign rd_limit = rd_word_r[2*FRAME_W-1:FRAME_W];

endmodule

// File: src/pfra_clip.sv
// Two-stage clip datapath for add-region requests: wide end sum, start
// selection, 4 GiB cap and page alignment. Depends on pfra_pkg.
module pfra_clip
  import pfra_pkg::*;
(
  input  logic              clk,
  input  logic              load,
  input  logic [63:0]       base,
  input  logic [63:0]       len,
  input  logic [31:0]       kind,
  input  logic [REND_W-1:0] rend,
  output clip_res_t         res
);

  logic [63:0] base_r;
  logic [63:0] len_r;
  logic        kind_ok_r;
  logic [64:0] end1_r;
  logic [63:0] start1_r;
  logic        ok1_r;
  clip_res_t   res_r;
  logic [63:0] rend_w;
  logic        end_le;
  logic        start_hi;
  logic        end_big;
  clip_res_t   res_nxt;

  assign rend_w = {{(64-REND_W){1'b0}}, rend};

  // Capture the offered entry when a beat is accepted.
  always_ff @(posedge clk) begin
    if (load) begin
      base_r    <= base;
      len_r     <= len;
      kind_ok_r <= (kind == 32'd1);
    end
  end

  // Stage one: end with carry, start raised to the reserved end.
  always_ff @(posedge clk) begin
    end1_r   <= {1'b0, base_r} + {1'b0, len_r};
    start1_r <= (base_r < rend_w) ? rend_w : base_r;
    ok1_r    <= kind_ok_r;
  end

  // Stage two: drop checks, round the start up and the capped end down.
  always_comb begin
    end_le   = !end1_r[64] && (end1_r[63:0] <= rend_w);
    start_hi = start1_r > START_MAX;
    end_big  = end1_r[64] || (end1_r[63:0] > PHYS_CAP);
    res_nxt.drop        = !ok1_r || end_le || start_hi;
    res_nxt.start_frame = {1'b0, start1_r[31:12]} + FRAME_W'(|start1_r[11:0]);
    res_nxt.end_frame   = end_big ? CAP_FRAME : end1_r[32:12];
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

// File: src/page_frame_range_allocator_core.sv
// Top level of the page frame range allocator: sequencer, shared frame
// comparator, count and output register. Depends on pfra_pkg, pfra_clip,
// pfra_table and assert_macros.svh.
//
// Channel  Direction  Handshake               Payload
// in_      slave      in_tvalid / in_tready   in_tdata, in_tuser
// out_     master     out_tvalid / out_tready out_tdata
// cfg_     slave      cfg_valid / cfg_ready   cfg_data
//
// An add beat passes from acceptance to a loaded result through capture,
// two clip stages, the table decision and the output load.
// An allocate beat is served by the one table read port, which visits one stored
// range per cycle until it finds a free frame or passes the last stored range.
// Reset clears the range count, the sequencer and out_tvalid, and sets the
// reserved end to 1 MiB; table contents are never read before they are written.
// A stalled result waits in the output register while the next beat is taken.
`include "assert_macros.svh"
module page_frame_range_allocator_core
  import pfra_pkg::*;
#(
  parameter int unsigned MAX_RANGES = 128
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: region_base[63:0], region_length[127:64], region_kind[159:128]
  input  logic [159:0] in_tdata,
  // in_tuser: req_type[0]
  input  logic         in_tuser,
  input  logic         in_tvalid,
  output logic         in_tready,
  // out_tdata: frame_addr[31:0], region_added[32], ready_res[33],
  // range_total[41:34], zero padding[47:42]
  output logic [47:0]  out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic [32:0]  cfg_data,
  input  logic         cfg_valid,
  output logic         cfg_ready
);

  localparam int unsigned CW = $clog2(MAX_RANGES + 1);
  localparam int unsigned AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLIP1  = 3'd1;
  localparam logic [2:0] ST_CLIP2  = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_SCAN   = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     stored_r, stored_nxt;
  logic [REND_W-1:0] rend_r, rend_nxt;
  logic [CW-1:0]     scan_idx_r, scan_idx_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]     chk_idx_r;
  logic              chk_last_r;
  logic [31:0]       res_addr_r, res_addr_nxt;
  logic              res_added_r, res_added_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [47:0]       out_data_r;

  logic              in_beat;
  logic              out_load;
  logic              issue;
  logic              hit;
  logic              miss_end;
  logic              add_ok;
  frame_t            cmp_a, cmp_b;
  logic              cmp_lt;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  frame_t            wr_first, wr_limit;
  frame_t            rd_first, rd_limit;
  clip_res_t         clip_res;
  logic [32:0]       cfg_floor;
  logic [7:0]        total8;

  assign in_tready = (state_r == ST_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Effective reserved end: at least 1 MiB, rounded up to a page.
  always_comb begin
    cfg_floor = (cfg_data < LOW_FLOOR) ? LOW_FLOOR : cfg_data;
    rend_nxt  = rend_r;
    if (cfg_valid) begin
      rend_nxt = ({1'b0, cfg_floor} + PAGE_MASK) & ~PAGE_MASK;
    end
  end

  pfra_clip u_clip (
    .clk  (clk),
    .load (in_beat),
    .base (in_tdata[63:0]),
    .len  (in_tdata[127:64]),
    .kind (in_tdata[159:128]),
    .rend (rend_r),
    .res  (clip_res)
  );

  // Shared frame comparator: range check during the scan, start below end
  // during the add decision.
  always_comb begin
    if (state_r == ST_SCAN) begin
      cmp_a = rd_first;
      cmp_b = rd_limit;
    end else begin
      cmp_a = clip_res.start_frame;
      cmp_b = clip_res.end_frame;
    end
  end
  assign cmp_lt = cmp_a < cmp_b;

  assign issue    = (state_r == ST_SCAN) && (scan_idx_r < stored_r);
  assign hit      = (state_r == ST_SCAN) && chk_vld_r && cmp_lt;
  assign miss_end = (state_r == ST_SCAN) && chk_vld_r && !cmp_lt && chk_last_r;
  assign add_ok   = (state_r == ST_DECIDE) && !clip_res.drop && cmp_lt &&
                    (stored_r < CW'(MAX_RANGES));

  // Table write: append on add, bump the first frame on a hit.
  always_comb begin
    wr_en    = add_ok || hit;
    wr_addr  = hit ? chk_idx_r : stored_r[AW-1:0];
    wr_first = hit ? (rd_first + FRAME_W'(1)) : clip_res.start_frame;
    wr_limit = hit ? rd_limit : clip_res.end_frame;
  end

  pfra_table #(
    .DEPTH (MAX_RANGES),
    .AW    (AW)
  ) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_first (wr_first),
    .wr_limit (wr_limit),
    .rd_en    (issue),
    .rd_addr  (scan_idx_r[AW-1:0]),
    .rd_first (rd_first),
    .rd_limit (rd_limit)
  );

  assign out_load = (state_r == ST_OUT) && (!out_vld_r || out_tready);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    stored_nxt    = stored_r;
    scan_idx_nxt  = scan_idx_r;
    chk_vld_nxt   = 1'b0;
    res_addr_nxt  = res_addr_r;
    res_added_nxt = res_added_r;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          res_addr_nxt  = 32'd0;
          res_added_nxt = 1'b0;
          scan_idx_nxt  = '0;
          if (!in_tuser) begin
            state_nxt = ST_CLIP1;
          end else if (stored_r == '0) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_CLIP1: state_nxt = ST_CLIP2;
      ST_CLIP2: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (add_ok) begin
          stored_nxt    = stored_r + CW'(1);
          res_added_nxt = 1'b1;
        end
        state_nxt = ST_OUT;
      end
      ST_SCAN: begin
        if (hit) begin
          res_addr_nxt = {rd_first[19:0], 12'h000};
          state_nxt    = ST_OUT;
        end else if (miss_end) begin
          state_nxt = ST_OUT;
        end else begin
          chk_vld_nxt = issue;
          if (issue) begin
            scan_idx_nxt = scan_idx_r + CW'(1);
          end
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  assign total8 = 8'(stored_r);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      stored_r   <= '0;
      rend_r     <= REND_RESET;
      scan_idx_r <= '0;
      chk_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      stored_r   <= stored_nxt;
      rend_r     <= rend_nxt;
      scan_idx_r <= scan_idx_nxt;
      chk_vld_r  <= chk_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    res_addr_r  <= res_addr_nxt;
    res_added_r <= res_added_nxt;
    chk_idx_r   <= scan_idx_r[AW-1:0];
    chk_last_r  <= ((scan_idx_r + CW'(1)) == stored_r);
    if (out_load) begin
      out_data_r <= {6'd0, total8, (stored_r != '0), res_added_r, res_addr_r};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // Checks on the sequencer and the range count.
  `PFRA_ASSERT(a_count_bound, stored_r <= CW'(MAX_RANGES), "range count above table depth")
  `PFRA_ASSERT(a_wr_state, wr_en |-> (state_r == ST_DECIDE || state_r == ST_SCAN),
               "table written outside decide or scan")
  `PFRA_ASSERT(a_count_step, (stored_r != $past(stored_r)) |->
               ($past(add_ok) && (stored_r == $past(stored_r) + CW'(1))),
               "range count changed without an append")
  `PFRA_ASSERT(a_out_return, out_load |=> (state_r == ST_IDLE && out_vld_r),
               "result load did not return to idle")

endmodule

// File: dv/tb_page_frame_range_allocator_core.sv
// Self-checking testbench for page_frame_range_allocator_core: directed table of beats,
// then random phases with sender idling and receiver stalls, all checked against a predictor.
// Depends on pfra_pkg and the RTL of the allocator core.
module tb_page_frame_range_allocator_core;
  import pfra_pkg::*;

  localparam int unsigned TABLE_DEPTH = 128;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned DRAIN_WAIT  = 150;
  localparam logic [63:0] PAGE_OFS    = 64'h0000_0000_0000_0FFF;
  localparam logic [31:0] KIND_RAM    = 32'd1;

  typedef enum logic {REQ_ADD = 1'b0, REQ_ALLOC = 1'b1} req_kind_t;

  // One result beat, laid out as out_tdata[41:0].
  typedef struct packed {
    logic [7:0]  total;
    logic        ready;
    logic        added;
    logic [31:0] addr;
  } frame_res_t;

  // One row of the directed part; an optional register write goes first.
  typedef struct packed {
    logic        cfg_first;
    logic [32:0] cfg_val;
    logic        req;
    logic [63:0] base;
    logic [63:0] len;
    logic [31:0] kind;
    logic        fixed;
    frame_res_t  res;
  } drill_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic [159:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [47:0]  out_tdata;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [32:0]  cfg_data = '0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;

  // Typed expectation that travels with the beat on the input channel.
  logic         beat_fixed = 1'b0;
  frame_res_t   beat_fixed_res = '0;

  // Predictor state: free ranges, range count and reserved end.
  frame_t       first_frame [TABLE_DEPTH];
  frame_t       limit_frame [TABLE_DEPTH];
  int unsigned  range_cnt = 0;
  logic [32:0]  rsv_end = 33'h0_0010_0000;

  frame_res_t   frames_expected[$];
  drill_row_t   drill[$];

  int unsigned  sender_idle_pct = 0;
  int unsigned  receiver_stall_pct = 0;
  int unsigned  mismatches = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  beats_taken = 0;
  int unsigned  results_seen = 0;
  int unsigned  regions_stored = 0;
  int unsigned  regions_dropped = 0;
  int unsigned  frames_given = 0;
  int unsigned  allocs_empty = 0;
  int unsigned  cfg_writes = 0;

  page_frame_range_allocator_core #(
    .MAX_RANGES(TABLE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_data  (cfg_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Work out the result of one accepted beat and update the predicted table.
  function automatic frame_res_t predict_frame_beat(input logic req, input logic [63:0] base,
                                                    input logic [63:0] len,
                                                    input logic [31:0] kind);
    frame_res_t  res;
    logic [64:0] sum;
    logic [63:0] rend;
    logic [63:0] start;
    logic [63:0] stop;
    logic        carry;
    logic        found;
    res = '0;
    if (req == REQ_ADD) begin
      if (kind == KIND_RAM) begin
        rend = (rsv_end < LOW_FLOOR) ? {31'h0, LOW_FLOOR} : {31'h0, rsv_end};
        rend = (rend + PAGE_OFS) & ~PAGE_OFS;
        sum = {1'b0, base} + {1'b0, len};
        carry = sum[64];
        if (carry || sum[63:0] > rend) begin
          start = (base < rend) ? rend : base;
          if (start <= START_MAX) begin
            start = (start + PAGE_OFS) & ~PAGE_OFS;
            stop = (carry || sum[63:0] > PHYS_CAP) ? PHYS_CAP : sum[63:0];
            stop = stop & ~PAGE_OFS;
            if (start < stop && range_cnt < TABLE_DEPTH) begin
              first_frame[range_cnt] = start[32:12];
              limit_frame[range_cnt] = stop[32:12];
              range_cnt++;
              res.added = 1'b1;
            end
          end
        end
      end
      if (res.added) regions_stored++;
      else regions_dropped++;
    end else begin
      // Allocation takes the first range that still has a free frame.
      found = 1'b0;
      for (int unsigned i = 0; i < range_cnt && !found; i++) begin
        if (first_frame[i] < limit_frame[i]) begin
          res.addr = {first_frame[i][19:0], 12'h000};
          first_frame[i] = first_frame[i] + frame_t'(1);
          found = 1'b1;
        end
      end
      if (found) frames_given++;
      else allocs_empty++;
    end
    res.ready = (range_cnt != 0);
    res.total = range_cnt[7:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 30)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Receiver: stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Monitor: predicts at each accepted input beat and checks each result beat.
  always @(posedge clk) begin : monitor
    frame_res_t got;
    frame_res_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        rsv_end = cfg_data;
        cfg_writes++;
      end
      if (in_tvalid && in_tready) begin
        want = predict_frame_beat(in_tuser, in_tdata[63:0], in_tdata[127:64],
                                  in_tdata[159:128]);
        if (beat_fixed) want = beat_fixed_res;
        frames_expected.push_back(want);
        beats_taken++;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[41:0];
        results_seen++;
        if (frames_expected.size() == 0) begin
          report_mismatch("result with nothing expected", 64'(got), '0);
        end else begin
          want = frames_expected.pop_front();
          if (got.addr != want.addr)
            report_mismatch("frame_addr", 64'(got.addr), 64'(want.addr));
          if (got.added != want.added)
            report_mismatch("region_added", 64'(got.added), 64'(want.added));
          if (got.ready != want.ready)
            report_mismatch("ready_res", 64'(got.ready), 64'(want.ready));
          if (got.total != want.total)
            report_mismatch("range_total", 64'(got.total), 64'(want.total));
        end
      end
    end
  end

  // Watchdog: counts cycles in which no channel moves a beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout after %0d cycles without a beat", IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  function automatic void put_row(input logic cfg_first, input logic [32:0] cfg_val,
                                  input logic req, input logic [63:0] base,
                                  input logic [63:0] len, input logic [31:0] kind,
                                  input logic fixed, input frame_res_t res);
    drill_row_t row;
    row = {cfg_first, cfg_val, req, base, len, kind, fixed, res};
    drill.push_back(row);
  endfunction

  // Present one beat after an optional idle gap and wait until it is taken.
  task automatic send_beat(input logic req, input logic [63:0] base, input logic [63:0] len,
                           input logic [31:0] kind, input logic fixed,
                           input frame_res_t res);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_tvalid      <= 1'b1;
    in_tuser       <= req;
    in_tdata       <= {kind, len, base};
    beat_fixed     <= fixed;
    beat_fixed_res <= res;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (frames_expected.size() != 0) @(posedge clk);
  endtask

  task automatic write_reserved_end(input logic [32:0] value);
    wait_drained();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random beat: allocations, well-formed RAM regions, and noise.
  task automatic drive_random_beat(input logic wide_ok);
    logic [63:0] base;
    logic [63:0] len;
    logic [63:0] pages;
    logic [31:0] kind;
    int unsigned pick;
    pick = $urandom_range(99);
    base = {$urandom, $urandom};
    len  = {$urandom, $urandom};
    kind = $urandom;
    if (pick < 55) begin
      send_beat(REQ_ALLOC, base, len, kind, 1'b0, '0);
    end else if (pick < 85) begin
      // Small regions above the reserved end keep allocations walking the table.
      pages = ($urandom_range(7) == 0) ? 64'($urandom_range(1, 64)) :
                                         64'($urandom_range(1, 8));
      base = {32'h0, $urandom};
      if (base < {31'h0, rsv_end})
        base = {31'h0, rsv_end} + 64'($urandom_range(0, 32'hF_FFFF));
      len = pages * 64'h1000 + 64'($urandom_range(0, 4095));
      if (wide_ok && $urandom_range(39) == 0) len = {$urandom, $urandom};
      send_beat(REQ_ADD, base, len, KIND_RAM, 1'b0, '0);
    end else begin
      // Noise: odd kinds, wrapping sums and starts close to 4 GiB.
      if ($urandom_range(1) == 0) kind = KIND_RAM;
      if ($urandom_range(3) == 0) base = START_MAX - 64'($urandom_range(0, 32'h3000));
      send_beat(REQ_ADD, base, len, kind, 1'b0, '0);
    end
  endtask

  task automatic run_phase(input int unsigned count, input int unsigned idle_in,
                           input int unsigned stall_out, input logic wide_ok,
                           input logic hold_midway);
    sender_idle_pct    = idle_in;
    receiver_stall_pct = stall_out;
    for (int unsigned n = 0; n < count; n++) begin
      if (hold_midway && n == count / 2) wait_drained();
      drive_random_beat(wide_ok);
    end
  endtask

  initial begin
    // Directed rows: empty table, dropped kinds, clipping, alignment, carry and 4 GiB edges.
    put_row(1'b0, '0, REQ_ALLOC, '0, '0, '0, 1'b1, '0);
    put_row(1'b0, '0, REQ_ADD, 64'h20_0000, 64'h1_0000, 32'hFFFF_FFFF, 1'b1, '0);
    put_row(1'b0, '0, REQ_ADD, 64'h20_0000, 64'h1_0000, 32'h0, 1'b1, '0);
    put_row(1'b0, '0, REQ_ADD, 64'h0, 64'h10_0000, KIND_RAM, 1'b1, '0);
    put_row(1'b0, '0, REQ_ADD, 64'h0, 64'h10_2000, KIND_RAM, 1'b0, '0);
    repeat (3) put_row(1'b0, '0, REQ_ALLOC, '0, '0, '0, 1'b0, '0);
    put_row(1'b0, '0, REQ_ADD, 64'h20_0001, 64'h2000, KIND_RAM, 1'b0, '0);
    put_row(1'b0, '0, REQ_ADD, 64'h30_0800, 64'h1000, KIND_RAM, 1'b0, '0);
    put_row(1'b0, '0, REQ_ADD, 64'hFFFF_F001, 64'h1_0000, KIND_RAM, 1'b0, '0);
    put_row(1'b0, '0, REQ_ADD, 64'hFFFF_F000, 64'h1000, KIND_RAM, 1'b0, '0);
    put_row(1'b0, '0, REQ_ADD, 64'hFFFF_FFFF_FFFF_F000, 64'h2000, KIND_RAM, 1'b0, '0);
    put_row(1'b0, '0, REQ_ADD, 64'hFFFF_E000, 64'hFFFF_FFFF_FFFF_F000, KIND_RAM, 1'b0, '0);
    put_row(1'b0, '0, REQ_ADD, 64'h1_0000_0000, 64'h1000, KIND_RAM, 1'b0, '0);
    repeat (5) put_row(1'b0, '0, REQ_ALLOC, '0, '0, '0, 1'b0, '0);
    put_row(1'b1, 33'h0, REQ_ADD, 64'h8_0000, 64'h8_1000, KIND_RAM, 1'b0, '0);
    put_row(1'b1, 33'h0_FFFF_E001, REQ_ADD, 64'h0, '1, KIND_RAM, 1'b0, '0);
    put_row(1'b1, 33'h1_0000_0000, REQ_ADD, '1, '1, KIND_RAM, 1'b0, '0);
    repeat (2) put_row(1'b0, '0, REQ_ALLOC, '0, '0, '0, 1'b0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (drill[r]) begin
      if (drill[r].cfg_first) write_reserved_end(drill[r].cfg_val);
      send_beat(drill[r].req, drill[r].base, drill[r].len, drill[r].kind,
                drill[r].fixed, drill[r].res);
    end

    // Random phases, each under its own reserved end and idling pattern.
    write_reserved_end(33'($urandom_range(0, 32'h4000_0000)));
    run_phase(450, 0, 0, 1'b0, 1'b0);
    write_reserved_end(33'h0);
    run_phase(450, 79, 0, 1'b0, 1'b1);
    write_reserved_end(33'($urandom_range(0, 32'h8000_0000)));
    run_phase(450, 0, 79, 1'b0, 1'b0);
    write_reserved_end(33'h0_0010_0000);
    run_phase(450, 7, 7, 1'b1, 1'b0);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    while (frames_expected.size() != 0) begin
      report_mismatch("result never returned", 64'(frames_expected.pop_front()), '0);
    end

    $display("Run covered %0d beats and %0d results under %0d reserved-end settings.",
             beats_taken, results_seen, cfg_writes);
    $display("Regions stored %0d, dropped %0d, table at %0d; frames %0d, empty allocs %0d.",
             regions_stored, regions_dropped, range_cnt, frames_given, allocs_empty);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
